[design/vnht_pkg.sv]
package vnht_pkg;

  localparam int IdxW      = 10;
  localparam int TableSize = 2 ** IdxW;
  localparam int RegW      = 10;
  localparam int RegCount  = 2 ** RegW;
  localparam int SweepLen  = (TableSize > RegCount) ? TableSize : RegCount;
  localparam int SweepW    = $clog2(SweepLen);

  localparam int CmdW  = 3;
  localparam int OpW   = 3;
  localparam int AW    = 10;
  localparam int BW    = 11;
  localparam int ResW  = 10;
  localparam int OffW  = 12;
  localparam int HashW = 14;

  localparam int KAdd = 10;
  localparam int KSub = 20;
  localparam int KMul = 30;

  typedef enum logic [CmdW-1:0] {
    CMD_LOOKUP     = 3'd0,
    CMD_INSERT     = 3'd1,
    CMD_STORE_VAR  = 3'd2,
    CMD_FIND_VAR   = 3'd3,
    CMD_RESET_KILL = 3'd4
  } cmd_e;

  localparam logic [OpW-1:0] OP_ADD   = 3'd0;
  localparam logic [OpW-1:0] OP_SUB   = 3'd1;
  localparam logic [OpW-1:0] OP_MUL   = 3'd2;
  localparam logic [OpW-1:0] OP_CONST = 3'd3;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PROBE,
    ST_KILL,
    ST_SCAN,
    ST_FREE,
    ST_WRITE,
    ST_CLEAR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [CmdW-1:0]        cmd;
    logic [OpW-1:0]         op;
    logic [AW-1:0]          a;
    logic signed [BW-1:0]   b;
    logic [ResW-1:0]        r;
    logic [OffW-1:0]        v;
  } req_t;

  // A variable binding keeps its offset in the operand fields.
  typedef struct packed {
    logic                   valid;
    logic                   is_var;
    logic [OpW-1:0]         op;
    logic [AW-1:0]          a;
    logic signed [BW-1:0]   b;
    logic [ResW-1:0]        res;
  } entry_t;

  typedef struct packed {
    logic                   en;
    logic [IdxW-1:0]        addr;
    entry_t                 data;
  } ent_wr_t;

  typedef struct packed {
    logic                   en;
    logic [RegW-1:0]        addr;
    logic                   data;
  } kill_wr_t;

  function automatic logic [IdxW-1:0] clamp_idx(input logic signed [HashW-1:0] s);
    logic [IdxW-1:0] idx;
    idx = s[IdxW-1:0];
    if (s < 0) begin
      idx = '0;
    end
    return idx;
  endfunction

  function automatic logic commutes(input logic [OpW-1:0] op);
    return (op == OP_ADD) || (op == OP_MUL);
  endfunction

  function automatic logic signed [HashW-1:0] op_k(input logic [OpW-1:0] op);
    logic signed [HashW-1:0] k;
    case (op)
      OP_ADD: k = HashW'(KAdd);
      OP_SUB: k = HashW'(KSub);
      OP_MUL: k = HashW'(KMul);
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [IdxW-1:0] expr_start(input logic [OpW-1:0] op,
                                                 input logic [AW-1:0] a,
                                                 input logic signed [BW-1:0] b);
    logic signed [HashW-1:0] k;
    logic signed [HashW-1:0] sx;
    logic signed [HashW-1:0] sy;
    logic [IdxW-1:0]         x;
    logic [IdxW-1:0]         y;
    k  = op_k(op);
    sx = $signed({{(HashW-AW-2){1'b0}}, a, 2'b00}) + HashW'(b) + k;
    sy = HashW'($signed({b, 2'b00})) + $signed({{(HashW-AW){1'b0}}, a}) + k;
    x  = clamp_idx(sx);
    y  = clamp_idx(sy);
    if (commutes(op) && (y < x)) begin
      x = y;
    end
    return x;
  endfunction

  function automatic logic [IdxW-1:0] var_start(input logic [OffW-1:0] v);
    logic [OffW+1:0] t;
    t = {v, 2'b10};
    return t[IdxW-1:0];
  endfunction

  function automatic logic [OffW-1:0] entry_off(input entry_t e);
    return {e.b[OffW-AW-1:0], e.a};
  endfunction

  function automatic logic expr_match(input entry_t e, input logic [OpW-1:0] op,
                                      input logic [AW-1:0] a,
                                      input logic signed [BW-1:0] b);
    logic same;
    logic swap;
    same = (e.a == a) && (e.b == b);
    swap = commutes(op) && ($signed({1'b0, e.a}) == b) && (e.b == $signed({1'b0, a}));
    return e.valid && !e.is_var && (e.op == op) && (same || swap);
  endfunction

  function automatic logic var_match(input entry_t e, input logic [OffW-1:0] v);
    return e.valid && e.is_var && (entry_off(e) == v);
  endfunction

  function automatic entry_t make_var(input logic [ResW-1:0] r, input logic [OffW-1:0] v);
    entry_t e;
    e.valid  = 1'b1;
    e.is_var = 1'b1;
    e.op     = OP_ADD;
    e.a      = v[AW-1:0];
    e.b      = $signed(BW'(v[OffW-1:AW]));
    e.res    = r;
    return e;
  endfunction

  function automatic entry_t make_expr(input logic [OpW-1:0] op, input logic [AW-1:0] a,
                                       input logic signed [BW-1:0] b,
                                       input logic [ResW-1:0] r);
    entry_t e;
    e.valid  = 1'b1;
    e.is_var = 1'b0;
    e.op     = op;
    e.a      = a;
    e.b      = b;
    e.res    = r;
    return e;
  endfunction

endpackage

[design/vnht_if.sv]
interface vnht_req_if;
  import vnht_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CmdW-1:0]      cmd;
  logic [OpW-1:0]       op_code;
  logic [AW-1:0]        operand_a;
  logic signed [BW-1:0] operand_b;
  logic [ResW-1:0]      result_reg;
  logic [OffW-1:0]      var_offset;

  modport source (output valid, cmd, op_code, operand_a, operand_b, result_reg, var_offset,
                  input ready);
  modport sink (input valid, cmd, op_code, operand_a, operand_b, result_reg, var_offset,
                output ready);
endinterface

interface vnht_rsp_if;
  import vnht_pkg::*;

  logic            valid;
  logic            ready;
  logic            hit;
  logic [ResW-1:0] found_reg;
  logic            table_full;

  modport source (output valid, hit, found_reg, table_full, input ready);
  modport sink (input valid, hit, found_reg, table_full, output ready);
endinterface

[design/vnht_entry_ram.sv]
module vnht_entry_ram (
  input  logic                    clk_i,
  input  vnht_pkg::ent_wr_t       wr_i,
  input  logic [vnht_pkg::IdxW-1:0] rd_addr_i,
  output vnht_pkg::entry_t        rd_data_o
);
  import vnht_pkg::*;

  entry_t mem_q [TableSize];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_q;
endmodule

[design/vnht_kill_ram.sv]
module vnht_kill_ram (
  input  logic                      clk_i,
  input  vnht_pkg::kill_wr_t        wr_i,
  input  logic [vnht_pkg::RegW-1:0] rd_addr_a_i,
  input  logic [vnht_pkg::RegW-1:0] rd_addr_b_i,
  output logic                      rd_data_a_o,
  output logic                      rd_data_b_o
);
  import vnht_pkg::*;

  logic mem_q [RegCount];
  logic rd_a_q;
  logic rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_a_q <= mem_q[rd_addr_a_i];
    rd_b_q <= mem_q[rd_addr_b_i];
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;
endmodule

[design/value_number_hash_table.sv]
// Value-numbering table for common subexpression elimination.
// Requests arrive on req_i (valid/ready); each request gives exactly one
// response on rsp_o (valid/ready) with hit, found_reg and table_full.
// The table is a 1024-entry memory with one read and one write port, read one
// slot per cycle; the kill set is a 1024-bit memory with two read ports.
// Steps, from acceptance to response valid:
//   lookup, find variable: a probe of up to 1024 slots, from the start slot
//   up to a match or the table end;
//   insert: the same plus a write of the new entry on a miss with a free slot;
//   store variable with an old binding: probe, a kill step, a full scan of
//   the table, a second probe for a free slot and a write;
//   reset kill set: one kill-set bit written per cycle, each cleared but
//   the bit of result_reg, which is set.
// The single entry read port sets the pace. One request is in work at a
// time; the next request is accepted while the previous response still
// waits on rsp_o, and it holds back its own response until the receiver
// has taken the earlier one. After reset the block sweeps both memories
// with req_i.ready low before it takes its first request.
module value_number_hash_table (
  input  logic      clk_i,
  input  logic      rst_ni,
  vnht_req_if.sink  req_i,
  vnht_rsp_if.source rsp_o
);
  import vnht_pkg::*;

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  logic [IdxW:0]     iss_q, iss_d;
  logic [SweepW-1:0] clr_q, clr_d;
  logic              s1_vld_q, s1_vld_d;
  logic [IdxW-1:0]   s1_idx_q, s1_idx_d;
  logic              s2_vld_q, s2_vld_d;
  logic [IdxW-1:0]   s2_idx_q, s2_idx_d;
  entry_t            s2_ent_q, s2_ent_d;
  logic              kw_en_q, kw_en_d;
  logic [RegW-1:0]   kw_idx_q, kw_idx_d;
  logic [IdxW-1:0]   fnd_idx_q, fnd_idx_d;
  logic [ResW-1:0]   fnd_res_q, fnd_res_d;
  logic              free_vld_q, free_vld_d;
  logic [IdxW-1:0]   free_idx_q, free_idx_d;
  logic              hit_q, hit_d;
  logic [ResW-1:0]   found_q, found_d;
  logic              full_q, full_d;
  logic              out_vld_q, out_vld_d;
  logic              out_hit_q, out_hit_d;
  logic [ResW-1:0]   out_found_q, out_found_d;
  logic              out_full_q, out_full_d;

  ent_wr_t           ent_wr;
  entry_t            ent_rdata;
  kill_wr_t          kill_wr;
  logic              kill_rd_a;
  logic              kill_rd_b;
  logic              req_ready;

  vnht_entry_ram u_entry_ram (
    .clk_i     (clk_i),
    .wr_i      (ent_wr),
    .rd_addr_i (iss_q[IdxW-1:0]),
    .rd_data_o (ent_rdata)
  );

  vnht_kill_ram u_kill_ram (
    .clk_i       (clk_i),
    .wr_i        (kill_wr),
    .rd_addr_a_i (RegW'(ent_rdata.a)),
    .rd_addr_b_i (RegW'(ent_rdata.b)),
    .rd_data_a_o (kill_rd_a),
    .rd_data_b_o (kill_rd_b)
  );

  always_comb begin
    logic is_var_cmd;
    logic mt;
    logic stop;
    logic issue;
    logic ka;
    logic kb;
    logic del;

    state_d     = state_q;
    req_d       = req_q;
    iss_d       = iss_q;
    clr_d       = clr_q;
    s1_vld_d    = 1'b0;
    s1_idx_d    = iss_q[IdxW-1:0];
    s2_vld_d    = 1'b0;
    s2_idx_d    = s1_idx_q;
    s2_ent_d    = ent_rdata;
    kw_en_d     = 1'b0;
    kw_idx_d    = kw_idx_q;
    fnd_idx_d   = fnd_idx_q;
    fnd_res_d   = fnd_res_q;
    free_vld_d  = free_vld_q;
    free_idx_d  = free_idx_q;
    hit_d       = hit_q;
    found_d     = found_q;
    full_d      = full_q;
    out_vld_d   = out_vld_q && !rsp_o.ready;
    out_hit_d   = out_hit_q;
    out_found_d = out_found_q;
    out_full_d  = out_full_q;
    ent_wr      = '0;
    kill_wr     = '0;
    req_ready   = 1'b0;
    issue       = 1'b0;
    stop        = 1'b0;
    ka          = 1'b0;
    kb          = 1'b0;
    del         = 1'b0;
    is_var_cmd  = (req_q.cmd == CMD_STORE_VAR) || (req_q.cmd == CMD_FIND_VAR);
    mt          = is_var_cmd ? var_match(ent_rdata, req_q.v)
                             : expr_match(ent_rdata, req_q.op, req_q.a, req_q.b);

    case (state_q)
      ST_INIT: begin
        ent_wr.en    = 32'(clr_q) < TableSize;
        ent_wr.addr  = IdxW'(clr_q);
        kill_wr.en   = 32'(clr_q) < RegCount;
        kill_wr.addr = RegW'(clr_q);
        clr_d        = clr_q + 1'b1;
        if (32'(clr_q) == SweepLen - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_i.valid) begin
          req_d.cmd  = req_i.cmd;
          req_d.op   = req_i.op_code;
          req_d.a    = req_i.operand_a;
          req_d.b    = req_i.operand_b;
          req_d.r    = req_i.result_reg;
          req_d.v    = req_i.var_offset;
          free_vld_d = 1'b0;
          hit_d      = 1'b0;
          found_d    = '0;
          full_d     = 1'b0;
          clr_d      = '0;
          case (req_i.cmd)
            CMD_LOOKUP, CMD_INSERT: begin
              iss_d   = {1'b0, expr_start(req_i.op_code, req_i.operand_a, req_i.operand_b)};
              state_d = ST_PROBE;
            end
            CMD_STORE_VAR, CMD_FIND_VAR: begin
              iss_d   = {1'b0, var_start(req_i.var_offset)};
              state_d = ST_PROBE;
            end
            CMD_RESET_KILL: begin
              state_d = ST_CLEAR;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_PROBE: begin
        if (s1_vld_q) begin
          if (!ent_rdata.valid && !free_vld_q) begin
            free_vld_d = 1'b1;
            free_idx_d = s1_idx_q;
          end
          stop = mt || (s1_idx_q == '1);
        end
        issue = !iss_q[IdxW] && !stop;
        if (stop) begin
          if (mt) begin
            hit_d     = 1'b1;
            found_d   = ent_rdata.res;
            fnd_idx_d = s1_idx_q;
            fnd_res_d = ent_rdata.res;
          end
          if ((req_q.cmd == CMD_STORE_VAR) && mt) begin
            state_d = ST_KILL;
          end else if (((req_q.cmd == CMD_INSERT) || (req_q.cmd == CMD_STORE_VAR)) && !mt) begin
            state_d = free_vld_d ? ST_WRITE : ST_DONE;
            full_d  = !free_vld_d;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_KILL: begin
        ent_wr.en    = 1'b1;
        ent_wr.addr  = fnd_idx_q;
        kill_wr.en   = 1'b1;
        kill_wr.addr = RegW'(fnd_res_q);
        kill_wr.data = 1'b1;
        iss_d        = '0;
        state_d      = ST_SCAN;
      end
      ST_SCAN: begin
        issue    = !iss_q[IdxW];
        s2_vld_d = s1_vld_q;
        if (s2_vld_q) begin
          ka  = kill_rd_a || (kw_en_q && (kw_idx_q == RegW'(s2_ent_q.a)));
          kb  = !s2_ent_q.b[BW-1]
                && (kill_rd_b || (kw_en_q && (kw_idx_q == RegW'(s2_ent_q.b))));
          del = s2_ent_q.valid && !s2_ent_q.is_var && (s2_ent_q.op != OP_CONST) && (ka || kb);
          if (del) begin
            ent_wr.en    = 1'b1;
            ent_wr.addr  = s2_idx_q;
            kill_wr.en   = 1'b1;
            kill_wr.addr = RegW'(s2_ent_q.res);
            kill_wr.data = 1'b1;
            kw_en_d      = 1'b1;
            kw_idx_d     = RegW'(s2_ent_q.res);
          end
          if (s2_idx_q == '1) begin
            iss_d      = {1'b0, var_start(req_q.v)};
            free_vld_d = 1'b0;
            state_d    = ST_FREE;
          end
        end
      end
      ST_FREE: begin
        if (s1_vld_q) begin
          if (!ent_rdata.valid) begin
            free_vld_d = 1'b1;
            free_idx_d = s1_idx_q;
          end
          stop = !ent_rdata.valid || (s1_idx_q == '1);
        end
        issue = !iss_q[IdxW] && !stop;
        if (stop) begin
          state_d = free_vld_d ? ST_WRITE : ST_DONE;
          full_d  = !free_vld_d;
        end
      end
      ST_WRITE: begin
        ent_wr.en   = 1'b1;
        ent_wr.addr = free_idx_q;
        ent_wr.data = is_var_cmd ? make_var(req_q.r, req_q.v)
                                 : make_expr(req_q.op, req_q.a, req_q.b, req_q.r);
        state_d     = ST_DONE;
      end
      ST_CLEAR: begin
        kill_wr.en   = 1'b1;
        kill_wr.addr = RegW'(clr_q);
        kill_wr.data = 32'(clr_q) == 32'(req_q.r);
        clr_d        = clr_q + 1'b1;
        if (32'(clr_q) == RegCount - 1) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d   = 1'b1;
          out_hit_d   = hit_q;
          out_found_d = found_q;
          out_full_d  = full_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (issue) begin
      iss_d    = iss_q + 1'b1;
      s1_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      clr_q     <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      kw_en_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      s1_vld_q  <= s1_vld_d;
      s2_vld_q  <= s2_vld_d;
      kw_en_q   <= kw_en_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    iss_q       <= iss_d;
    s1_idx_q    <= s1_idx_d;
    s2_idx_q    <= s2_idx_d;
    s2_ent_q    <= s2_ent_d;
    kw_idx_q    <= kw_idx_d;
    fnd_idx_q   <= fnd_idx_d;
    fnd_res_q   <= fnd_res_d;
    free_vld_q  <= free_vld_d;
    free_idx_q  <= free_idx_d;
    hit_q       <= hit_d;
    found_q     <= found_d;
    full_q      <= full_d;
    out_hit_q   <= out_hit_d;
    out_found_q <= out_found_d;
    out_full_q  <= out_full_d;
  end

  assign req_i.ready      = req_ready;
  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.hit        = out_hit_q;
  assign rsp_o.found_reg  = out_found_q;
  assign rsp_o.table_full = out_full_q;
endmodule

[design/vnht_checker.sv]
module vnht_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      req_valid_i,
  input logic                      req_ready_i,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic                      rsp_hit_i,
  input logic [vnht_pkg::ResW-1:0] rsp_found_reg_i,
  input logic                      rsp_table_full_i
);
  import vnht_pkg::*;

  // A held response keeps its value until it is taken.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(rsp_hit_i)
      && $stable(rsp_found_reg_i) && $stable(rsp_table_full_i)))
    else $error("response changed while stalled");

  // The block works on one request at a time, so it is busy right after accepting one.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request accepted while busy");

  // A miss never reports a register.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_hit_i) |-> (rsp_found_reg_i == '0))
    else $error("miss with nonzero register");
endmodule

bind value_number_hash_table vnht_checker u_vnht_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_hit_i        (rsp_o.hit),
  .rsp_found_reg_i  (rsp_o.found_reg),
  .rsp_table_full_i (rsp_o.table_full)
);
